/* hdl/fpa_pkg.sv */
// fpa_pkg: mode codes used by the fixed_point_alu top level
// no dependencies
`default_nettype none
package fpa_pkg;
  typedef enum logic [3:0] {
    MODE_ADD = 4'd0, MODE_SUB = 4'd1, MODE_MUL = 4'd2, MODE_DIV = 4'd3,
    MODE_MIN = 4'd4, MODE_MAX = 4'd5, MODE_INC = 4'd6, MODE_DEC = 4'd7,
    MODE_TOINT = 4'd8, MODE_FROMINT = 4'd9
  } mode_t;
  localparam int IO_WIDTH = 32;
endpackage
`default_nettype wire

/* hdl/fpa_div.sv */
// fpa_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing; magnitudes in, rounded magnitude quotient out
`default_nettype none
module fpa_div #(
  parameter int NW = 40,
  parameter int DW = 32,
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [TW-1:0] tag_in,
  output logic               out_valid,
  output logic [NW:0]        quot,
  output logic [TW-1:0]      tag_out
);
  logic          v   [NW+1];
  logic [NW-1:0] n   [NW+1];
  logic [DW:0]   rm  [NW+1];
  logic [NW-1:0] q   [NW+1];
  logic [DW-1:0] d   [NW+1];
  logic [TW-1:0] tg  [NW+1];

  assign v[0]  = in_valid;
  assign n[0]  = num;
  assign rm[0] = '0;
  assign q[0]  = '0;
  assign d[0]  = den;
  assign tg[0] = tag_in;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    assign sh = {rm[i], n[i][NW-1-i]};
    assign df = sh - {2'b00, d[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
      n[i+1]  <= n[i];
      d[i+1]  <= d[i];
      tg[i+1] <= tg[i];
      if (!df[DW+1]) begin
        rm[i+1] <= df[DW:0];
        q[i+1]  <= {q[i][NW-2:0], 1'b1};
      end else begin
        rm[i+1] <= sh[DW:0];
        q[i+1]  <= {q[i][NW-2:0], 1'b0};
      end
    end
  end

  // round half away: remainder at least half the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v[NW];
    end
    tag_out <= tg[NW];
    quot <= {1'b0, q[NW]} + (NW+1)'({rm[NW], 1'b0} >= {2'b00, d[NW]});
  end
endmodule
`default_nettype wire

/* hdl/fixed_point_alu.sv */
// fixed_point_alu: top level of the signed fixed-point alu
// depends on fpa_pkg and fpa_div
`default_nettype none
// Usage: drive mode, operand_a and operand_b with start high; busy is always
// low, so a transaction is taken every cycle. Each transaction yields one
// result, shown for exactly one cycle with done high, in issue order.
// One input register stage, then the divider retires one quotient bit per
// pipeline stage plus its rounding stage; the product rides a delay line of
// matching depth and all other modes ride the divider as its tag, so every
// mode reaches done through the same registers. Throughput is one
// transaction per cycle. The multiply is a single stage, the rounding and
// saturation a further stage. Reset clears all valid bits; payload is not
// cleared. The receiver cannot stall: results must be taken when shown.
module fixed_point_alu #(
  parameter int FRAC_BITS  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  mode,
  input  wire logic signed [31:0] operand_a,
  input  wire logic signed [31:0] operand_b,
  output logic             done,
  output logic signed [31:0] result,
  output logic             greater,
  output logic             less,
  output logic             equal,
  output logic             overflow,
  output logic             divide_by_zero
);
  localparam int W  = DATA_WIDTH;
  localparam int NW = W + FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int TW = 4 + 1 + 1 + 1 + 1 + 1 + 1 + 2 * W + 2;
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

  typedef struct packed {
    logic [3:0]   md;
    logic         gt;
    logic         lt;
    logic         eq;
    logic         neg;
    logic         dz;
    logic         ovf;
    logic [W-1:0] r;
    logic [W-1:0] aux;
    logic [1:0]   pad;
  } tag_t;

  assign busy = 1'b0;

  // stage 1: load, compare, simple modes, magnitudes
  logic [W-1:0] a, b, ma, mb;
  logic         gt_c, lt_c;
  assign a = W'(64'(signed'(operand_a)));
  assign b = W'(64'(signed'(operand_b)));
  assign ma = a[W-1] ? -a : a;
  assign mb = b[W-1] ? -b : b;
  assign gt_c = $signed(a) > $signed(b);
  assign lt_c = $signed(a) < $signed(b);

  logic [W-1:0] sr;
  logic         so;
  logic [W:0]   sum;
  logic [W-1:0] sft;
  always_comb begin
    sr = '0;
    so = 1'b0;
    sum = '0;
    sft = a << FRAC_BITS;
    unique case (mode)
      fpa_pkg::MODE_ADD, fpa_pkg::MODE_SUB, fpa_pkg::MODE_INC,
      fpa_pkg::MODE_DEC: begin
        priority if (mode == fpa_pkg::MODE_ADD) begin
          sum = {a[W-1], a} + {b[W-1], b};
        end else if (mode == fpa_pkg::MODE_SUB) begin
          sum = {a[W-1], a} - {b[W-1], b};
        end else if (mode == fpa_pkg::MODE_INC) begin
          sum = {a[W-1], a} + (W+1)'(1);
        end else begin
          sum = {a[W-1], a} - (W+1)'(1);
        end
        if (sum[W] != sum[W-1]) begin
          so = 1'b1;
          sr = a[W-1] ? SMIN : SMAX;
        end else begin
          sr = sum[W-1:0];
        end
      end
      fpa_pkg::MODE_MIN: sr = lt_c ? a : b;
      fpa_pkg::MODE_MAX: sr = gt_c ? a : b;
      fpa_pkg::MODE_TOINT: sr = W'($signed(a) >>> FRAC_BITS);
      fpa_pkg::MODE_FROMINT: begin
        if (W'($signed(sft) >>> FRAC_BITS) != a) begin
          so = 1'b1;
          sr = a[W-1] ? SMIN : SMAX;
        end else begin
          sr = sft;
        end
      end
      default: sr = '0;
    endcase
  end

  tag_t t0;
  always_comb begin
    t0.md  = mode;
    t0.gt  = gt_c;
    t0.lt  = lt_c;
    t0.eq  = (a == b);
    t0.neg = a[W-1] ^ b[W-1];
    t0.dz  = (mode == fpa_pkg::MODE_DIV) && (b == '0);
    t0.ovf = so;
    t0.r   = sr;
    t0.aux = mb;
    t0.pad = '0;
  end

  // register stage 1
  logic         v1;
  tag_t         t1;
  logic [W-1:0] ma1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    t1  <= t0;
    ma1 <= ma;
  end

  // stage 2: multiply of magnitudes, alongside the divider
  logic [PW-1:0] prod2;
  always_ff @(posedge clk) begin
    prod2 <= ma1 * t1.aux;
  end

  // dividend is the magnitude scaled by the fraction bits
  logic [NW-1:0] num1;
  assign num1 = NW'(ma1) << FRAC_BITS;

  logic          vd;
  logic [NW:0]   qd;
  tag_t          td;
  fpa_div #(.NW(NW), .DW(W), .TW(TW)) u_div (
    .clk, .rst,
    .in_valid (v1),
    .num      (num1),
    .den      (t1.aux),
    .tag_in   (t1),
    .out_valid(vd),
    .quot     (qd),
    .tag_out  (td)
  );

  // product rides a delay line matching the divider
  localparam int DL = NW;
  logic [PW-1:0] pd [DL];
  always_ff @(posedge clk) begin
    pd[0] <= prod2;
    for (int i = 1; i < DL; i++) pd[i] <= pd[i-1];
  end

  // final stage: round product, saturate, select
  logic [PW:0]  pr;
  logic [PW:0]  mag;
  logic [W-1:0] fr;
  logic         fo;
  logic         ng;
  always_comb begin
    pr = {1'b0, pd[DL-1]} + ((PW+1)'(1) << FRAC_BITS >> 1);
    if (FRAC_BITS == 0) pr = {1'b0, pd[DL-1]};
    mag = '0;
    fr = td.r;
    fo = td.ovf;
    ng = 1'b0;
    if (td.md == fpa_pkg::MODE_MUL || (td.md == fpa_pkg::MODE_DIV && !td.dz)) begin
      if (td.md == fpa_pkg::MODE_MUL) mag = pr >> FRAC_BITS;
      else mag = (PW+1)'(qd);
      ng = td.neg && (mag != '0);
      if (mag > (ng ? (PW+1)'(SMIN) : (PW+1)'(SMAX))) begin
        fo = 1'b1;
        fr = ng ? SMIN : SMAX;
      end else begin
        fr = ng ? -mag[W-1:0] : mag[W-1:0];
      end
    end else if (td.md == fpa_pkg::MODE_DIV) begin
      fr = '0;
      fo = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
    result         <= 32'(signed'(fr));
    greater        <= td.gt;
    less           <= td.lt;
    equal          <= td.eq;
    overflow       <= fo;
    divide_by_zero <= td.dz;
  end

`ifndef NO_ASSERTIONS
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> $countones({greater, less, equal}) == 1) else $error("compare flags");
  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (result == '0 && !overflow)) else $error("div zero");
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy");
`endif
endmodule
`default_nettype wire
